FILE: rtl/opsa_pkg.sv
// ----------------------------------------------------------------------------
// opsa_pkg
// Shared types and codes for the object pool stack allocator.
// ----------------------------------------------------------------------------
package opsa_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_POOL_SIZE     = 2'd0;
    localparam logic [1:0] REG_CLEAN_ENABLE  = 2'd1;
    localparam logic [1:0] REG_DELETE_ENABLE = 2'd2;

    // Width of the fixed handle fields on the ports.
    localparam int PORT_HANDLE_W = 16;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_GIVEN     = 3'd0,
        STAT_EXHAUSTED = 3'd1,
        STAT_RETURNED  = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_NULL      = 3'd4
    } status_t;

    // Classified request kinds passed from the front to the back.
    typedef enum logic [1:0] {
        CMD_GET,
        CMD_NULL,
        CMD_RET
    } cmd_kind_t;

    // Configuration register contents.
    typedef struct packed {
        logic [4:0] pool_size;
        logic       clean_enable;
        logic       delete_enable;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic [PORT_HANDLE_W-1:0] out_handle;
        logic                     created_new;
        logic                     clean_issued;
        logic                     delete_issued;
        status_t                  status;
    } res_t;

endpackage

FILE: rtl/opsa_front.sv
// ----------------------------------------------------------------------------
// opsa_front
// Accepts request beats, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module opsa_front import opsa_pkg::*; #(
    parameter int HANDLE_BITS = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic [PORT_HANDLE_W-1:0] handle,
    output logic                     cmd_valid,
    input  logic                     cmd_ready,
    output cmd_kind_t                cmd_kind,
    output logic [HANDLE_BITS-1:0]   cmd_handle
);

    localparam int DEPTH = 2;

    cmd_kind_t              kind_q [DEPTH];
    logic [HANDLE_BITS-1:0] hndl_q [DEPTH];
    logic                   wr_ptr_reg;
    logic                   rd_ptr_reg;
    logic [1:0]             count_reg;
    logic [63:0]            handle_wide;
    logic [HANDLE_BITS-1:0] handle_masked;
    cmd_kind_t              kind_in;
    logic                   push;
    logic                   pop;

    // Mask the handle to the built handle width and classify the request.
    assign handle_wide   = 64'(handle);
    assign handle_masked = handle_wide[HANDLE_BITS-1:0];

    always_comb
    begin
        if (!func)
        begin
            kind_in = CMD_GET;
        end
        else if (handle_masked == '0)
        begin
            kind_in = CMD_NULL;
        end
        else
        begin
            kind_in = CMD_RET;
        end
    end

    assign in_ready   = (count_reg != 2'(DEPTH));
    assign cmd_valid  = (count_reg != 2'd0);
    assign cmd_kind   = kind_q[rd_ptr_reg];
    assign cmd_handle = hndl_q[rd_ptr_reg];
    assign push       = in_valid && in_ready;
    assign pop        = cmd_valid && cmd_ready;

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_q[wr_ptr_reg] <= kind_in;
            hndl_q[wr_ptr_reg] <= handle_masked;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/opsa_back.sv
// ----------------------------------------------------------------------------
// opsa_back
// Carries out get and return requests on the slot table and holds the result.
// ----------------------------------------------------------------------------
module opsa_back import opsa_pkg::*; #(
    parameter int MAX_SLOTS   = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_t                   cfg,
    input  logic                   cmd_valid,
    output logic                   cmd_ready,
    input  cmd_kind_t              cmd_kind,
    input  logic [HANDLE_BITS-1:0] cmd_handle,
    output logic                   res_valid,
    input  logic                   res_ready,
    output res_t                   res
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int AW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int EW = (CW > 5) ? CW : 5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_GET,
        ST_SRCH,
        ST_SWAP
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          cursor_reg;
    logic [HANDLE_BITS-1:0] fresh_reg;
    logic [HANDLE_BITS-1:0] hreg_reg;
    logic [AW-1:0]          idx_reg;
    logic [MAX_SLOTS-1:0]   vld_reg;
    logic                   res_valid_reg;
    res_t                   res_reg;

    logic [HANDLE_BITS-1:0] mem [MAX_SLOTS];
    logic [HANDLE_BITS-1:0] rd_data_reg;
    logic                   rd_vld_reg;

    logic [AW-1:0]          mem_raddr;
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [HANDLE_BITS-1:0] mem_wdata;

    logic [CW-1:0]          cur_top;
    logic [AW-1:0]          top_addr;
    logic [AW-1:0]          cur_addr;
    logic [HANDLE_BITS-1:0] entry;
    logic                   hit;
    logic                   res_free;
    logic                   start;
    logic                   exhausted;
    logic [HANDLE_BITS-1:0] fresh_inc;
    logic [63:0]            entry_wide;
    logic [63:0]            fresh_wide;

    // Helper values derived from the cursor and the last table read.
    assign cur_top    = cursor_reg - CW'(1);
    assign top_addr   = cur_top[AW-1:0];
    assign cur_addr   = cursor_reg[AW-1:0];
    assign entry      = rd_vld_reg ? rd_data_reg : '0;
    assign hit        = (entry == hreg_reg);
    assign res_free   = !res_valid_reg || res_ready;
    assign start      = (state_reg == ST_IDLE) && cmd_valid && res_free;
    assign cmd_ready  = start;
    assign exhausted  = (EW'(cursor_reg) >= EW'(cfg.pool_size)) ||
                        (EW'(cursor_reg) >= EW'(MAX_SLOTS));
    assign fresh_inc  = fresh_reg + HANDLE_BITS'(1);
    assign entry_wide = 64'(entry);
    assign fresh_wide = 64'(fresh_reg);
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    // Table port control for the current step.
    always_comb
    begin
        mem_raddr = cur_addr;
        mem_we    = 1'b0;
        mem_waddr = cur_addr;
        mem_wdata = fresh_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_kind == CMD_RET)
                begin
                    mem_raddr = top_addr;
                end
            end
            ST_GET:
            begin
                if (entry == '0)
                begin
                    mem_we = 1'b1;
                end
            end
            ST_SRCH:
            begin
                if (hit)
                begin
                    // Fetch the old top entry while the found handle goes to the top.
                    mem_raddr = top_addr;
                    mem_we    = 1'b1;
                    mem_waddr = top_addr;
                    mem_wdata = hreg_reg;
                end
                else
                begin
                    mem_raddr = idx_reg - AW'(1);
                end
            end
            ST_SWAP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = entry;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Slot table memory with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
        rd_vld_reg  <= vld_reg[mem_raddr];
    end

    // Request sequencer, cursor, fresh counter and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cursor_reg    <= '0;
            fresh_reg     <= HANDLE_BITS'(1);
            vld_reg       <= '0;
            res_valid_reg <= 1'b0;
            hreg_reg      <= '0;
            idx_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            if (res_valid_reg && res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                vld_reg[mem_waddr] <= 1'b1;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        res_reg  <= '0;
                        hreg_reg <= cmd_handle;
                        unique case (cmd_kind)
                            CMD_GET:
                            begin
                                if (exhausted)
                                begin
                                    res_reg.status <= STAT_EXHAUSTED;
                                    res_valid_reg  <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= ST_GET;
                                end
                            end
                            CMD_NULL:
                            begin
                                res_reg.status <= STAT_NULL;
                                res_valid_reg  <= 1'b1;
                            end
                            CMD_RET:
                            begin
                                if (cursor_reg == '0)
                                begin
                                    res_reg.status        <= STAT_NOT_FOUND;
                                    res_reg.delete_issued <= cfg.delete_enable;
                                    res_valid_reg         <= 1'b1;
                                end
                                else
                                begin
                                    idx_reg   <= top_addr;
                                    state_reg <= ST_SRCH;
                                end
                            end
                            default:
                            begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_GET:
                begin
                    // An empty slot gets a fresh handle; the counter never yields null.
                    if (entry == '0)
                    begin
                        res_reg.out_handle  <= fresh_wide[PORT_HANDLE_W-1:0];
                        res_reg.created_new <= 1'b1;
                        fresh_reg           <= (fresh_inc == '0) ? HANDLE_BITS'(1)
                                                                 : fresh_inc;
                    end
                    else
                    begin
                        res_reg.out_handle <= entry_wide[PORT_HANDLE_W-1:0];
                    end
                    res_reg.status <= STAT_GIVEN;
                    res_valid_reg  <= 1'b1;
                    cursor_reg     <= cursor_reg + CW'(1);
                    state_reg      <= ST_IDLE;
                end
                ST_SRCH:
                begin
                    if (hit)
                    begin
                        cursor_reg <= cur_top;
                        if (idx_reg == top_addr)
                        begin
                            res_reg.status       <= STAT_RETURNED;
                            res_reg.clean_issued <= cfg.clean_enable;
                            res_valid_reg        <= 1'b1;
                            state_reg            <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SWAP;
                        end
                    end
                    else if (idx_reg == '0)
                    begin
                        res_reg.status        <= STAT_NOT_FOUND;
                        res_reg.delete_issued <= cfg.delete_enable;
                        res_valid_reg         <= 1'b1;
                        state_reg             <= ST_IDLE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg - AW'(1);
                    end
                end
                ST_SWAP:
                begin
                    res_reg.status       <= STAT_RETURNED;
                    res_reg.clean_issued <= cfg.clean_enable;
                    res_valid_reg        <= 1'b1;
                    state_reg            <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: rtl/object_pool_stack_allocator_core.sv
// ----------------------------------------------------------------------------
// object_pool_stack_allocator_core
// Pool of reusable object handles kept as a slot table with a use cursor.
// ----------------------------------------------------------------------------
// Usage:
// Request beats arrive on s_axis: tuser selects get (0) or return (1), tdata
// carries the handle being returned. Every request yields exactly one result
// beat on m_axis, in request order: tdata is the handle given out, tuser holds
// the created, clean and delete flags and the status code.
// The cfg channel writes pool_size (index 0), clean_enable (1) and
// delete_enable (2); it is always ready, and the user must write it only
// while idle: the block itself does not enforce this. A get passes through
// the get state of the execution unit, while an exhausted get, a null return
// or a return to an empty pool is answered straight from idle. A return
// searches the slot table one entry per cycle from the top and then moves
// the found handle to the top. Requests pass through a two-beat request
// queue and then the result register.
// Reset empties the slot table through per-slot valid bits at once, clears
// the cursor, sets the fresh handle counter to one and loads the register
// defaults. When m_axis stalls, the result is held, the queue keeps taking
// requests until it is full, and then s_axis_tready falls.
// ----------------------------------------------------------------------------
module object_pool_stack_allocator_core import opsa_pkg::*; #(
    parameter int MAX_SLOTS   = 16,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] handle
    input  logic [0:0]  s_axis_tuser,   // [0] func
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_handle
    output logic [5:0]  m_axis_tuser,   // [0] created_new, [1] clean_issued,
                                        // [2] delete_issued, [5:3] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [4:0]  cfg_data
);

    cfg_t                   cfg_reg;
    logic                   cmd_valid;
    logic                   cmd_ready;
    cmd_kind_t              cmd_kind;
    logic [HANDLE_BITS-1:0] cmd_handle;
    res_t                   res;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pool_size     <= 5'd16;
            cfg_reg.clean_enable  <= 1'b0;
            cfg_reg.delete_enable <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                REG_POOL_SIZE:     cfg_reg.pool_size     <= cfg_data;
                REG_CLEAN_ENABLE:  cfg_reg.clean_enable  <= cfg_data[0];
                REG_DELETE_ENABLE: cfg_reg.delete_enable <= cfg_data[0];
                default:           cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Request intake and queue.
    opsa_front #(
        .HANDLE_BITS (HANDLE_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .func       (s_axis_tuser[0]),
        .handle     (s_axis_tdata),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_kind   (cmd_kind),
        .cmd_handle (cmd_handle)
    );

    // Execution on the slot table.
    opsa_back #(
        .MAX_SLOTS   (MAX_SLOTS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_kind   (cmd_kind),
        .cmd_handle (cmd_handle),
        .res_valid  (m_axis_tvalid),
        .res_ready  (m_axis_tready),
        .res        (res)
    );

    // Result beat packing.
    assign m_axis_tdata = res.out_handle;
    assign m_axis_tuser = {res.status, res.delete_issued, res.clean_issued,
                           res.created_new};

endmodule
